// ===== sv/omni_drive_pid_mixer_top_defines.svh =====
// Assertion macros for the omni drive mixer
`ifndef OMNI_DRIVE_PID_MIXER_TOP_DEFINES_SVH
`define OMNI_DRIVE_PID_MIXER_TOP_DEFINES_SVH
`ifndef SYNTH
// Clocked check, disabled while reset is asserted
`define ODPM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("odpm assertion failed");
// Clocked check that also holds during reset
`define ODPM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("odpm assertion failed");
`else
`define ODPM_ASSERT(lbl, prop)
`define ODPM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== sv/odpm_pkg.sv =====
package odpm_pkg;

    // Mixer coefficients, Q.16
    localparam logic [16:0] COEF_0866 = 17'd56754;

    // Register map indexes
    typedef enum logic [2:0] {
        REG_USE_GYRO    = 3'd0,
        REG_GAIN_P      = 3'd1,
        REG_GAIN_I_DT   = 3'd2,
        REG_GAIN_D      = 3'd3,
        REG_LIN_LIMIT   = 3'd4,
        REG_YAW_LIMIT   = 3'd5,
        REG_WHEEL_RAD   = 3'd6,
        REG_RECIP_SPEED = 3'd7
    } reg_idx_t;

    // Servo action codes
    typedef enum logic [1:0] {
        SERVO_NONE    = 2'd0,
        SERVO_ANG45   = 2'd1,
        SERVO_ANG90   = 2'd2,
        SERVO_STOP    = 2'd3
    } servo_t;

    typedef struct packed {
        logic        use_gyro;
        logic [15:0] gain_p;
        logic [23:0] gain_i_dt;
        logic [19:0] gain_d_over_dt;
        logic [14:0] lin_limit;
        logic [14:0] yaw_limit;
        logic [9:0]  wheel_radius;
        logic [23:0] lin_recip;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PI,
        ST_PP,
        ST_PD,
        ST_PDI,
        ST_CLAMP,
        ST_ROT,
        ST_VX,
        ST_SUM,
        ST_W1,
        ST_W2,
        ST_W3,
        ST_FIN
    } state_t;

    // Shared multiplier operand select
    typedef enum logic [2:0] {
        MS_EI,
        MS_EP,
        MS_ED,
        MS_ROT,
        MS_VX,
        MS_W1,
        MS_W2,
        MS_W3
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     int_upd;
        logic     om_p;
        logic     om_di;
        logic     clamp;
        logic     rot_cap;
        logic     sum_en;
        logic     wh1_cap;
        logic     wh2_cap;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic out_stall;
    } sts_t;

endpackage

// ===== sv/odpm_ifs.sv =====
// Input channel: one control tick per beat
interface odpm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target_vx;
    logic signed [15:0] target_vy;
    logic signed [15:0] target_omega;
    logic signed [15:0] gyro_rate;
    logic               kick_request;

    modport source (output valid, target_vx, target_vy, target_omega, gyro_rate,
                    kick_request, input ready);
    modport sink (input valid, target_vx, target_vy, target_omega, gyro_rate,
                  kick_request, output ready);
endinterface

// Output channel: wheel speeds and kick status
interface odpm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] wheel1_speed;
    logic signed [15:0] wheel2_speed;
    logic signed [15:0] wheel3_speed;
    logic [1:0]         servo_action;
    logic               kick_busy;

    modport source (output valid, wheel1_speed, wheel2_speed, wheel3_speed,
                    servo_action, kick_busy, input ready);
    modport sink (input valid, wheel1_speed, wheel2_speed, wheel3_speed,
                  servo_action, kick_busy, output ready);
endinterface

// ===== sv/odpm_regs.sv =====
module odpm_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output odpm_pkg::cfg_t     cfg
);
    import odpm_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_gyro        <= 1'b0;
            cfg_reg.gain_p          <= 16'd410;
            cfg_reg.gain_i_dt       <= 24'd3355;
            cfg_reg.gain_d_over_dt  <= 20'd4096;
            cfg_reg.lin_limit       <= 15'd500;
            cfg_reg.yaw_limit       <= 15'd1536;
            cfg_reg.wheel_radius    <= 10'd40;
            cfg_reg.lin_recip       <= 24'd33554;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_USE_GYRO:    cfg_reg.use_gyro        <= pwdata[0];
                REG_GAIN_P:      cfg_reg.gain_p          <= pwdata[15:0];
                REG_GAIN_I_DT:   cfg_reg.gain_i_dt       <= pwdata[23:0];
                REG_GAIN_D:      cfg_reg.gain_d_over_dt  <= pwdata[19:0];
                REG_LIN_LIMIT:   cfg_reg.lin_limit       <= pwdata[14:0];
                REG_YAW_LIMIT:   cfg_reg.yaw_limit       <= pwdata[14:0];
                REG_WHEEL_RAD:   cfg_reg.wheel_radius    <= pwdata[9:0];
                REG_RECIP_SPEED: cfg_reg.lin_recip       <= pwdata[23:0];
            endcase
        end
    end

    // readback
    always_comb
    begin
        unique case (idx)
            REG_USE_GYRO:    prdata = {31'd0, cfg_reg.use_gyro};
            REG_GAIN_P:      prdata = {16'd0, cfg_reg.gain_p};
            REG_GAIN_I_DT:   prdata = {8'd0, cfg_reg.gain_i_dt};
            REG_GAIN_D:      prdata = {12'd0, cfg_reg.gain_d_over_dt};
            REG_LIN_LIMIT:   prdata = {17'd0, cfg_reg.lin_limit};
            REG_YAW_LIMIT:   prdata = {17'd0, cfg_reg.yaw_limit};
            REG_WHEEL_RAD:   prdata = {22'd0, cfg_reg.wheel_radius};
            REG_RECIP_SPEED: prdata = {8'd0, cfg_reg.lin_recip};
        endcase
    end

endmodule

// ===== sv/odpm_ctrl.sv =====
`include "omni_drive_pid_mixer_top_defines.svh"
module odpm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           use_gyro,
    input  odpm_pkg::sts_t sts,
    output logic           in_ready,
    output odpm_pkg::cmd_t cmd
);
    import odpm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = use_gyro ? ST_PI : ST_CLAMP;
            end
            ST_PI:    state_next = ST_PP;
            ST_PP:    state_next = ST_PD;
            ST_PD:    state_next = ST_PDI;
            ST_PDI:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_ROT;
            ST_ROT:   state_next = ST_VX;
            ST_VX:    state_next = ST_SUM;
            ST_SUM:   state_next = ST_W1;
            ST_W1:    state_next = ST_W2;
            ST_W2:    state_next = ST_W3;
            ST_W3:    state_next = ST_FIN;
            ST_FIN:
            begin
                if (!sts.out_stall)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // command decode
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MS_EI;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_EI;
            end
            ST_PP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_EP;
                cmd.int_upd = 1'b1;
            end
            ST_PD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_ED;
                cmd.om_p    = 1'b1;
            end
            ST_PDI:   cmd.om_di = 1'b1;
            ST_CLAMP: cmd.clamp = 1'b1;
            ST_ROT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_ROT;
            end
            ST_VX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_VX;
                cmd.rot_cap = 1'b1;
            end
            ST_SUM:   cmd.sum_en = 1'b1;
            ST_W1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_W1;
            end
            ST_W2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_W2;
                cmd.wh1_cap = 1'b1;
            end
            ST_W3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_W3;
                cmd.wh2_cap = 1'b1;
            end
            ST_FIN:   cmd.finish = !sts.out_stall;
            default:  cmd = '0;
        endcase
    end

    `ODPM_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)
    `ODPM_ASSERT(a_finish_no_stall, cmd.finish |-> !sts.out_stall)
    `ODPM_ASSERT(a_load_route, cmd.load |=> (state_reg == ST_PI || state_reg == ST_CLAMP))

endmodule

// ===== sv/odpm_dp.sv =====
module odpm_dp #(
    parameter int KICK_EXTEND_TICKS = 170,
    parameter int KICK_END_TICKS    = 220
) (
    input  logic           clk,
    input  logic           rst_n,
    input  odpm_pkg::cfg_t cfg,
    input  odpm_pkg::cmd_t cmd,
    output odpm_pkg::sts_t sts,
    odpm_in_if.sink        in_ch,
    odpm_out_if.source     out_ch
);
    import odpm_pkg::*;

    localparam logic [7:0] EXT_T = 8'(KICK_EXTEND_TICKS);
    localparam logic [7:0] END_T = 8'(KICK_END_TICKS);

    // latched tick inputs
    logic signed [15:0] vx_reg, vy_reg;
    logic signed [16:0] e_reg;
    logic               req_reg;
    logic signed [29:0] om_reg;
    // PID state
    logic signed [31:0] int_reg;
    logic signed [17:0] prev_reg;
    // mixer
    logic signed [15:0] om_c_reg;
    logic signed [36:0] rot_reg;
    logic signed [36:0] w1_reg, w2_reg, w3_reg;
    logic signed [61:0] prod_reg;
    logic signed [15:0] wh1_reg, wh2_reg;
    // kick
    logic               kick_act_reg;
    logic [7:0]         kick_ticks_reg;
    // output
    logic               ov_reg;
    logic signed [15:0] o1_reg, o2_reg, o3_reg;
    logic [1:0]         oact_reg;
    logic               obusy_reg;

    logic signed [36:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [61:0] sh16, sh12, sh25;
    logic signed [32:0] int_sum;
    logic signed [31:0] int_sat;
    logic signed [16:0] spd_lim, vx_c, vy_c;
    logic signed [29:0] om_lim, om_c;
    logic signed [36:0] vy15, vy16;
    logic signed [15:0] wh_sat;
    logic               k_act;
    logic [7:0]         k_ticks;
    servo_t             k_action;
    logic               k_act_next;
    logic [7:0]         k_ticks_next;

    // shared multiplier operand select
    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_EI:
            begin
                mul_a = 37'(e_reg);
                mul_b = $signed({1'b0, cfg.gain_i_dt});
            end
            MS_EP:
            begin
                mul_a = 37'(e_reg);
                mul_b = 25'($signed({1'b0, cfg.gain_p}));
            end
            MS_ED:
            begin
                mul_a = 37'(e_reg) - 37'(prev_reg);
                mul_b = 25'($signed({1'b0, cfg.gain_d_over_dt}));
            end
            MS_ROT:
            begin
                mul_a = 37'(om_c_reg);
                mul_b = 25'($signed({1'b0, cfg.wheel_radius}));
            end
            MS_VX:
            begin
                mul_a = 37'(vx_reg);
                mul_b = 25'($signed({1'b0, COEF_0866}));
            end
            MS_W1:
            begin
                mul_a = w1_reg;
                mul_b = $signed({1'b0, cfg.lin_recip});
            end
            MS_W2:
            begin
                mul_a = w2_reg;
                mul_b = $signed({1'b0, cfg.lin_recip});
            end
            MS_W3:
            begin
                mul_a = w3_reg;
                mul_b = $signed({1'b0, cfg.lin_recip});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // floor shifts of the product
    assign sh16 = prod_reg >>> 16;
    assign sh12 = prod_reg >>> 12;
    assign sh25 = prod_reg >>> 25;

    // integral accumulate with 32-bit saturation
    always_comb
    begin
        int_sum = 33'(int_reg) + sh16[32:0];
        if (int_sum > 33'sh0_7FFF_FFFF)
            int_sat = 32'sh7FFF_FFFF;
        else if (int_sum < -33'sh0_8000_0000)
            int_sat = 32'sh8000_0000;
        else
            int_sat = int_sum[31:0];
    end

    // symmetric clamps
    always_comb
    begin
        spd_lim = $signed({2'b00, cfg.lin_limit});
        om_lim  = 30'($signed({1'b0, cfg.yaw_limit}));
        vx_c    = 17'(vx_reg);
        vy_c    = 17'(vy_reg);
        if (vx_c > spd_lim)       vx_c = spd_lim;
        else if (vx_c < -spd_lim) vx_c = -spd_lim;
        if (vy_c > spd_lim)       vy_c = spd_lim;
        else if (vy_c < -spd_lim) vy_c = -spd_lim;
        om_c = om_reg;
        if (om_c > om_lim)        om_c = om_lim;
        else if (om_c < -om_lim)  om_c = -om_lim;
    end

    assign vy15 = 37'(vy_reg) <<< 15;
    assign vy16 = 37'(vy_reg) <<< 16;

    // wheel scale and saturation
    always_comb
    begin
        if (sh25 > 62'sd32767)
            wh_sat = 16'sh7FFF;
        else if (sh25 < -62'sd32768)
            wh_sat = 16'sh8000;
        else
            wh_sat = sh25[15:0];
    end

    // kick timer step
    always_comb
    begin
        k_act        = kick_act_reg || req_reg;
        k_ticks      = kick_act_reg ? kick_ticks_reg : 8'd0;
        k_action     = SERVO_NONE;
        k_act_next   = k_act;
        k_ticks_next = kick_ticks_reg;
        if (k_act)
        begin
            if (k_ticks < EXT_T)
                k_action = SERVO_ANG45;
            else if (k_ticks < END_T)
                k_action = SERVO_ANG90;
            else
            begin
                k_action   = SERVO_STOP;
                k_act_next = 1'b0;
            end
            k_ticks_next = k_ticks + 8'd1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vx_reg  <= in_ch.target_vx;
            vy_reg  <= in_ch.target_vy;
            e_reg   <= 17'(in_ch.target_omega) - 17'(in_ch.gyro_rate);
            om_reg  <= 30'(in_ch.target_omega);
            req_reg <= in_ch.kick_request;
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.om_p)
            om_reg <= om_reg + sh12[29:0];
        if (cmd.om_di)
            om_reg <= om_reg + sh12[29:0] + 30'(int_reg >>> 8);
        if (cmd.clamp)
        begin
            vx_reg   <= vx_c[15:0];
            vy_reg   <= vy_c[15:0];
            om_c_reg <= om_c[15:0];
        end
        if (cmd.rot_cap)
            rot_reg <= {prod_reg[28:0], 8'd0};
        if (cmd.sum_en)
        begin
            w1_reg <= prod_reg[36:0] + vy15 + rot_reg;
            w2_reg <= rot_reg - vy16;
            w3_reg <= rot_reg + vy15 - prod_reg[36:0];
        end
        if (cmd.wh1_cap)
            wh1_reg <= wh_sat;
        if (cmd.wh2_cap)
            wh2_reg <= wh_sat;
        if (cmd.finish)
        begin
            o1_reg    <= wh1_reg;
            o2_reg    <= wh2_reg;
            o3_reg    <= wh_sat;
            oact_reg  <= k_action;
            obusy_reg <= k_act_next;
        end
    end

    // PID, kick and output control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_reg        <= '0;
            prev_reg       <= '0;
            kick_act_reg   <= 1'b0;
            kick_ticks_reg <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.int_upd)
                int_reg <= int_sat;
            if (cmd.om_di)
                prev_reg <= 18'(e_reg);
            if (cmd.finish)
            begin
                kick_act_reg   <= k_act_next;
                kick_ticks_reg <= k_ticks_next;
                ov_reg         <= 1'b1;
            end
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    assign sts.out_stall      = ov_reg && !out_ch.ready;
    assign out_ch.valid        = ov_reg;
    assign out_ch.wheel1_speed = o1_reg;
    assign out_ch.wheel2_speed = o2_reg;
    assign out_ch.wheel3_speed = o3_reg;
    assign out_ch.servo_action = oact_reg;
    assign out_ch.kick_busy    = obusy_reg;

endmodule

// ===== sv/omni_drive_pid_mixer_top.sv =====
// Three-wheel omni drive mixer with PID yaw-rate feedback and kick timer.
// in_ch carries one control tick per beat (target velocities, gyro rate,
// kick request); out_ch returns one beat per tick with three Q1.15 wheel
// speeds, the servo action and the kick busy flag. Registers are written
// through the APB port; the user must write them only while the block is idle,
// as the block itself does not enforce this. A single shared multiplier
// is sequenced through up to eight products (PID terms, rotation term, x
// coefficient, three reciprocal scalings).
// A new tick is taken only after the previous one has reached the output
// register; in_ch.ready is high only while the sequencer is idle.
// A result waits in the output register while the next tick is processed;
// if the receiver still stalls when the next result is done, the sequencer
// holds in its last step until the output beat is taken.
// Reset clears the PID integral, previous error, kick timer and the output
// valid, and loads the registers with their default values.
module omni_drive_pid_mixer_top #(
    parameter int KICK_EXTEND_TICKS = 170,
    parameter int KICK_END_TICKS    = 220
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    odpm_in_if.sink     in_ch,
    odpm_out_if.source  out_ch
);
    import odpm_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    odpm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    odpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .use_gyro (cfg.use_gyro),
        .sts      (sts),
        .in_ready (in_ch.ready),
        .cmd      (cmd)
    );

    odpm_dp #(
        .KICK_EXTEND_TICKS (KICK_EXTEND_TICKS),
        .KICK_END_TICKS    (KICK_END_TICKS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cmd    (cmd),
        .sts    (sts),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

// ===== sim/tb_omni_drive_pid_mixer_top.sv =====
module tb_omni_drive_pid_mixer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import odpm_pkg::*;

    localparam int KICK_EXTEND   = 170;
    localparam int KICK_END      = 220;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 8;
    localparam int BEATS_PER_PH  = 150;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] omega;
        logic signed [15:0] gyro;
        logic               kick;
    } tick_t;

    typedef struct packed {
        logic signed [15:0] w1;
        logic signed [15:0] w2;
        logic signed [15:0] w3;
        servo_t             act;
        logic               busy;
    } wheels_t;

    typedef struct {
        tick_t   tick;
        bit      typed;
        wheels_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    odpm_in_if  in_ch();
    odpm_out_if out_ch();

    omni_drive_pid_mixer_top #(
        .KICK_EXTEND_TICKS(KICK_EXTEND),
        .KICK_END_TICKS(KICK_END)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always #2 clk = ~clk;

    // Shadow of the block's registers and state
    cfg_t        mix_cfg;
    logic signed [31:0] integ;
    logic signed [17:0] prev_err;
    logic        kicking;
    logic [7:0]  kick_cnt;

    wheels_t     wheel_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function automatic longint clamp_lim(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic signed [15:0] scale_wheel(longint num);
        longint w;
        w = (num * longint'(mix_cfg.lin_recip)) >>> 25;
        if (w > 32767) w = 32767;
        if (w < -32768) w = -32768;
        return w[15:0];
    endfunction

    // One control tick: PID, clamp, mix, kick timer
    function automatic wheels_t mix_tick(tick_t t);
        longint  vx, vy, om, e, acc, rot;
        wheels_t r;
        vx = t.vx;
        vy = t.vy;
        om = t.omega;
        if (mix_cfg.use_gyro)
        begin
            e = longint'(t.omega) - longint'(t.gyro);
            acc = longint'(integ) + ((e * longint'(mix_cfg.gain_i_dt)) >>> 16);
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            integ = acc[31:0];
            om = om + ((e * longint'(mix_cfg.gain_p)) >>> 12)
                    + (longint'(integ) >>> 8)
                    + (((e - longint'(prev_err)) * longint'(mix_cfg.gain_d_over_dt)) >>> 12);
            prev_err = e[17:0];
        end
        vx = clamp_lim(vx, longint'(mix_cfg.lin_limit));
        vy = clamp_lim(vy, longint'(mix_cfg.lin_limit));
        om = clamp_lim(om, longint'(mix_cfg.yaw_limit));
        rot = longint'(mix_cfg.wheel_radius) * om * 256;
        r.w1 = scale_wheel(56754 * vx + 32768 * vy + rot);
        r.w2 = scale_wheel(-65536 * vy + rot);
        r.w3 = scale_wheel(-56754 * vx + 32768 * vy + rot);
        if (t.kick && !kicking)
        begin
            kicking = 1'b1;
            kick_cnt = '0;
        end
        r.act = SERVO_NONE;
        if (kicking)
        begin
            if (kick_cnt < KICK_EXTEND) r.act = SERVO_ANG45;
            else if (kick_cnt < KICK_END) r.act = SERVO_ANG90;
            else
            begin
                r.act = SERVO_STOP;
                kicking = 1'b0;
            end
            kick_cnt = kick_cnt + 8'd1;
        end
        r.busy = kicking;
        return r;
    endfunction

    // APB write: setup then access
    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_cfg(cfg_t c);
        reg_write(REG_USE_GYRO,    32'(c.use_gyro));
        reg_write(REG_GAIN_P,      32'(c.gain_p));
        reg_write(REG_GAIN_I_DT,   32'(c.gain_i_dt));
        reg_write(REG_GAIN_D,      32'(c.gain_d_over_dt));
        reg_write(REG_LIN_LIMIT,   32'(c.lin_limit));
        reg_write(REG_YAW_LIMIT,   32'(c.yaw_limit));
        reg_write(REG_WHEEL_RAD,   32'(c.wheel_radius));
        reg_write(REG_RECIP_SPEED, 32'(c.lin_recip));
        mix_cfg = c;
    endtask

    // Drive one tick beat, expectation pushed at the accepting edge
    task automatic send_tick(tick_t t, bit typed, wheels_t want);
        wheels_t got;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.target_vx    <= t.vx;
        in_ch.target_vy    <= t.vy;
        in_ch.target_omega <= t.omega;
        in_ch.gyro_rate    <= t.gyro;
        in_ch.kick_request <= t.kick;
        do @(posedge clk); while (!in_ch.ready);
        got = mix_tick(t);
        wheel_q.push_back(typed ? want : got);
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        while (wheel_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_field(int lim);
        int s;
        s = $urandom_range(9);
        if (s < 2) return 16'($urandom());
        if (s == 2) return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
        if (lim < 1) lim = 1;
        if (lim > 32767) lim = 32767;
        return 16'(int'($urandom_range(2 * lim)) - lim);
    endfunction

    // Output side: random stall, compare against the oldest expectation
    always @(posedge clk)
    begin
        wheels_t want;
        cycles <= cycles + 1;
        out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (wheel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat");
            end
            else
            begin
                want = wheel_q.pop_front();
                if (out_ch.wheel1_speed !== want.w1 || out_ch.wheel2_speed !== want.w2 ||
                    out_ch.wheel3_speed !== want.w3 || out_ch.servo_action !== want.act ||
                    out_ch.kick_busy !== want.busy)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp w=%0d/%0d/%0d act=%0d busy=%0d got w=%0d/%0d/%0d act=%0d busy=%0d",
                                 want.w1, want.w2, want.w3, want.act, want.busy,
                                 out_ch.wheel1_speed, out_ch.wheel2_speed,
                                 out_ch.wheel3_speed, out_ch.servo_action, out_ch.kick_busy);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_omni_drive_pid_mixer_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.target_vx = '0;
        in_ch.target_vy = '0;
        in_ch.target_omega = '0;
        in_ch.gyro_rate = '0;
        in_ch.kick_request = 1'b0;
        out_ch.ready = 1'b0;
    end

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        cfg_t     c;
        tick_t    t;
        wheels_t  zero_out;
        int       bias;

        mix_cfg = '{use_gyro: 1'b0, gain_p: 16'd410, gain_i_dt: 24'd3355,
                    gain_d_over_dt: 20'd4096, lin_limit: 15'd500, yaw_limit: 15'd1536,
                    wheel_radius: 10'd40, lin_recip: 24'd33554};
        integ = '0;
        prev_err = '0;
        kicking = 1'b0;
        kick_cnt = '0;
        zero_out = '{w1: 16'sd0, w2: 16'sd0, w3: 16'sd0, act: SERVO_NONE, busy: 1'b0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, reset configuration, gyro off
        row.typed = 1'b0;
        row.want = zero_out;
        row.tick = '0;                                       row.typed = 1'b1; rows.push_back(row);
        row.tick = '0; row.tick.gyro = 16'sh7fff;            rows.push_back(row);
        row.tick = '0; row.tick.gyro = 16'sh8000;            rows.push_back(row);
        row.typed = 1'b0;
        row.tick = '0; row.tick.vx = 16'sh7fff;              rows.push_back(row);
        row.tick = '0; row.tick.vx = 16'sh8000;              rows.push_back(row);
        row.tick = '0; row.tick.vy = 16'sh7fff;              rows.push_back(row);
        row.tick = '0; row.tick.vy = 16'sh8000;              rows.push_back(row);
        row.tick = '0; row.tick.omega = 16'sh7fff;           rows.push_back(row);
        row.tick = '0; row.tick.omega = 16'sh8000;           rows.push_back(row);
        row.tick = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0}; rows.push_back(row);
        row.tick = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0}; rows.push_back(row);
        // kick start shows extend at once
        row.tick = '0; row.tick.kick = 1'b1; row.typed = 1'b1;
        row.want = '{w1: 16'sd0, w2: 16'sd0, w3: 16'sd0, act: SERVO_ANG45, busy: 1'b1};
        rows.push_back(row);
        row.typed = 1'b0;
        // request while kicking is ignored
        row.tick = '{16'sd100, -16'sd200, 16'sd300, 16'sd0, 1'b1}; rows.push_back(row);
        row.tick = '{-16'sd499, 16'sd499, -16'sd1536, 16'sd5, 1'b0}; rows.push_back(row);
        foreach (rows[k]) send_tick(rows[k].tick, rows[k].typed, rows[k].want);
        drain();

        for (int ph = 1; ph < PHASES; ph++)
        begin
            c = mix_cfg;
            unique case (ph)
                1: c.use_gyro = 1'b1;
                2: c = '{1'b1, 16'hffff, 24'hffffff, 20'hfffff, 15'h7fff, 15'h7fff,
                         10'h3ff, 24'hffffff};
                3: c = '{1'b0, 16'd0, 24'd0, 20'd0, 15'd0, 15'd0, 10'd0, 24'd512};
                4: c = '{1'b1, 16'd0, 24'd0, 20'd0, 15'd1, 15'd1, 10'd1, 24'd0};
                6:
                begin
                    c = cfg_t'(125'($urandom()));
                    c.use_gyro = 1'b1;
                    c.gain_i_dt = 24'hffffff;
                end
                default: c = cfg_t'(125'({$urandom(), $urandom(), $urandom(), $urandom()}));
            endcase
            load_cfg(c);
            send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? 76 : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 76 : 0;
            if (ph % 4 == 3)
            begin
                send_idle_pct = 13;
                recv_stall_pct = 13;
            end
            // biased error drives the integral toward saturation
            bias = (ph == 6) ? 2 : int'($urandom_range(1));
            for (int n = 0; n < BEATS_PER_PH; n++)
            begin
                t.vx    = rand_field(int'(c.lin_limit) + 10);
                t.vy    = rand_field(int'(c.lin_limit) + 10);
                t.omega = rand_field(int'(c.yaw_limit) + 10);
                if (bias == 2)
                begin
                    t.omega = (n < 100) ? 16'sh7fff : 16'sh8000;
                    t.gyro  = (n < 100) ? 16'sh8000 : 16'sh7fff;
                end
                else if ($urandom_range(3) == 0)
                    t.gyro = 16'($urandom());
                else
                    t.gyro = 16'(int'(t.omega) + int'($urandom_range(64)) - 32);
                t.kick = ($urandom_range(19) == 0);
                send_tick(t, 1'b0, zero_out);
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb_omni_drive_pid_mixer_top: PASS");
        else
            $display("tb_omni_drive_pid_mixer_top: FAIL");
        $finish;
    end
endmodule
